FILE: src/psched_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared beat types, field widths and sequencer states of the scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 12;
	localparam int PRIO_W = 8;
	localparam int RES_W  = 17;
	localparam int PNUM_W = 7;

	// Largest time value a result field can show.
	localparam logic [RES_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [ARR_W-1:0]  arrival_time;
		logic [BUR_W-1:0]  burst_time;
		logic [PRIO_W-1:0] prio_level;
		logic              last_process;
	} proc_item_t;

	typedef struct packed {
		logic [PNUM_W-1:0] process_number;
		logic [RES_W-1:0]  completion_time;
		logic [RES_W-1:0]  turnaround_time;
		logic [RES_W-1:0]  waiting_time;
		logic              last_result;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_TICK,
		ST_OUT
	} state_t;

endpackage

FILE: src/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads a set of processes, simulates preemptive priority scheduling one time
// unit at a time and reports completion, turnaround and waiting times.
// ----------------------------------------------------------------------------
// Processes are loaded one beat per cycle while busy is low; the beat with
// last_process set starts the run, and busy falls in the cycle that carries the
// last result. A run consists of a setup sweep, then for each scheduled time
// unit or idle-time jump a full sweep of the process tables through their
// single read port followed by an update step, one extra sweep after the
// last completion, and a final sweep that streams the results. Results appear
// in load order, one per cycle, each on result for exactly one cycle marked by
// result_valid; the receiver cannot stall them. A beat that arrives when the
// tables are full is dropped, though its last_process flag still starts the
// run. Times above 131071 saturate at 131071.
module preemptive_priority_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  psched_pkg::proc_item_t proc_item,
	output logic                   result_valid,
	output psched_pkg::result_t    result
);
	import psched_pkg::*;

	localparam int IdxW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CntW  = $clog2(MAX_PROCS + 1);
	localparam int TimeW = $clog2((1 << ARR_W) + MAX_PROCS * ((1 << BUR_W) - 1));
	localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PROCS);

	// Process tables.
	logic [ARR_W-1:0]  arr_mem  [MAX_PROCS];
	logic [BUR_W-1:0]  bur_mem  [MAX_PROCS];
	logic [PRIO_W-1:0] pri_mem  [MAX_PROCS];
	logic [BUR_W-1:0]  rem_mem  [MAX_PROCS];
	logic [TimeW-1:0]  fin_mem  [MAX_PROCS];

	state_t state_q, state_d;

	logic [CntW-1:0]  loaded_q, done_q;
	logic [TimeW-1:0] time_q;
	logic [IdxW-1:0]  ptr_q, last_idx;
	logic             issue_q;

	logic              vld_s1, last_s1;
	logic [IdxW-1:0]   idx_s1;
	logic [ARR_W-1:0]  arr_s1;
	logic [BUR_W-1:0]  bur_s1;
	logic [PRIO_W-1:0] pri_s1;
	logic [BUR_W-1:0]  rem_s1;
	logic [TimeW-1:0]  fin_s1;

	logic             vld_s2, last_s2;
	logic [IdxW-1:0]  idx_s2;
	logic [TimeW-1:0] tat_s2;
	logic [TimeW-1:0] fin_s2;
	logic [BUR_W-1:0] bur_s2;

	logic              found_q, nxt_vld_q;
	logic [PRIO_W-1:0] best_q;
	logic [IdxW-1:0]   pick_q;
	logic [BUR_W-1:0]  pick_rem_q;
	logic [ARR_W-1:0]  nxt_arr_q;

	logic    res_vld_q;
	result_t res_q;

	logic             accept, load_we, sweep_begin, all_done;
	logic             rem_we, fin_we;
	logic [IdxW-1:0]  rem_wa, fin_wa;
	logic [BUR_W-1:0] rem_wd;
	logic [TimeW-1:0] fin_wd;
	logic             scan_live, scan_ready, take_pick, take_nxt;
	logic [TimeW-1:0] wait_s2;

	function automatic logic [RES_W-1:0] sat(input logic [TimeW-1:0] v);
		if (v > TimeW'(TIME_MAX)) begin
			return TIME_MAX;
		end
		return v[RES_W-1:0];
	endfunction

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign load_we  = accept && (loaded_q < MaxCnt);
	assign last_idx = IdxW'(loaded_q - 1'b1);
	assign all_done = (done_q == loaded_q);

	// Scan evaluation of the entry whose table data arrived this cycle.
	assign scan_live  = (state_q == ST_SCAN) && vld_s1 && (rem_s1 != '0);
	assign scan_ready = ({{(TimeW-ARR_W){1'b0}}, arr_s1} <= time_q);
	assign take_pick  = scan_live && scan_ready && (!found_q || (pri_s1 > best_q));
	assign take_nxt   = scan_live && !scan_ready && (!nxt_vld_q || (arr_s1 < nxt_arr_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && proc_item.last_process) state_d = ST_INIT;
			end
			ST_INIT: begin
				if (vld_s1 && last_s1) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (vld_s1 && last_s1) state_d = ST_TICK;
			end
			ST_TICK: begin
				state_d = all_done ? ST_OUT : ST_SCAN;
			end
			ST_OUT: begin
				if (vld_s2 && last_s2) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: sweep launch and table write ports.
	always_comb begin
		sweep_begin = (state_q != state_d) &&
			((state_d == ST_INIT) || (state_d == ST_SCAN) || (state_d == ST_OUT));
		rem_we = 1'b0;
		rem_wa = idx_s1;
		rem_wd = bur_s1;
		fin_we = 1'b0;
		fin_wa = idx_s1;
		fin_wd = {{(TimeW-ARR_W){1'b0}}, arr_s1};
		unique case (state_q)
			ST_INIT: begin
				rem_we = vld_s1;
				fin_we = vld_s1 && (bur_s1 == '0);
			end
			ST_TICK: begin
				rem_wa = pick_q;
				rem_wd = pick_rem_q - 1'b1;
				fin_wa = pick_q;
				fin_wd = time_q + 1'b1;
				rem_we = !all_done && found_q;
				fin_we = !all_done && found_q && (pick_rem_q == BUR_W'(1));
			end
			ST_IDLE, ST_SCAN, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Table memories, registered read at the sweep pointer.
	always_ff @(posedge clk) begin
		if (load_we) begin
			arr_mem[loaded_q[IdxW-1:0]] <= proc_item.arrival_time;
			bur_mem[loaded_q[IdxW-1:0]] <= proc_item.burst_time;
			pri_mem[loaded_q[IdxW-1:0]] <= proc_item.prio_level;
		end
		arr_s1 <= arr_mem[ptr_q];
		bur_s1 <= bur_mem[ptr_q];
		pri_s1 <= pri_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_wa] <= rem_wd;
		end
		rem_s1 <= rem_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (fin_we) begin
			fin_mem[fin_wa] <= fin_wd;
		end
		fin_s1 <= fin_mem[ptr_q];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			loaded_q  <= '0;
			done_q    <= '0;
			time_q    <= '0;
			ptr_q     <= '0;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
			found_q   <= 1'b0;
			nxt_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			vld_s1    <= issue_q;
			vld_s2    <= vld_s1 && (state_q == ST_OUT);
			res_vld_q <= vld_s2;

			if (load_we) begin
				loaded_q <= loaded_q + 1'b1;
			end else if ((state_q == ST_OUT) && vld_s2 && last_s2) begin
				loaded_q <= '0;
			end

			if (sweep_begin) begin
				ptr_q   <= '0;
				issue_q <= 1'b1;
			end else if (issue_q) begin
				if (ptr_q == last_idx) begin
					issue_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end

			if ((state_q == ST_IDLE) && (state_d == ST_INIT)) begin
				done_q <= '0;
				time_q <= '0;
			end else if (rem_we && (rem_wd == '0)) begin
				// A zero burst in setup or the last unit of a process finishes it.
				done_q <= done_q + 1'b1;
			end

			if ((state_q == ST_TICK) && !all_done) begin
				if (found_q) begin
					time_q <= time_q + 1'b1;
				end else if (nxt_vld_q) begin
					time_q <= {{(TimeW-ARR_W){1'b0}}, nxt_arr_q};
				end
			end

			if (sweep_begin && (state_d == ST_SCAN)) begin
				found_q   <= 1'b0;
				nxt_vld_q <= 1'b0;
			end else begin
				if (take_pick) found_q <= 1'b1;
				if (take_nxt) nxt_vld_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		idx_s1  <= ptr_q;
		last_s1 <= (ptr_q == last_idx);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		tat_s2  <= fin_s1 - {{(TimeW-ARR_W){1'b0}}, arr_s1};
		fin_s2  <= fin_s1;
		bur_s2  <= bur_s1;
		if (take_pick) begin
			best_q     <= pri_s1;
			pick_q     <= idx_s1;
			pick_rem_q <= rem_s1;
		end
		if (take_nxt) begin
			nxt_arr_q <= arr_s1;
		end
		res_q.process_number  <= PNUM_W'(idx_s2) + 1'b1;
		res_q.completion_time <= sat(fin_s2);
		res_q.turnaround_time <= sat(tat_s2);
		res_q.waiting_time    <= sat(wait_s2);
		res_q.last_result     <= last_s2;
	end

	assign wait_s2      = tat_s2 - {{(TimeW-BUR_W){1'b0}}, bur_s2};
	assign result_valid = res_vld_q;
	assign result       = res_q;

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe outside a run");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= MaxCnt)
		else $error("load count beyond table depth");

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (done_q <= loaded_q))
		else $error("more processes finished than loaded");

	a_pick_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) && found_q |-> (pick_rem_q != '0))
		else $error("picked a finished process");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && proc_item.last_process |=> busy)
		else $error("last beat did not start a run");

endmodule
